// ===== design/capt_pkg.sv =====
// capt_pkg: shared types, constants and helpers for the cell area/perimeter table
// used by every module of cell_area_perimeter_table but capt_ram; depends on nothing else

package capt_pkg;

    // sizing
    localparam int MAX_CELLS  = 255;
    localparam int NEIGHBORS  = 8;
    localparam int AREA_BITS  = 16;
    localparam int ID_BITS    = 8;
    localparam int PERIM_BITS = 16;
    localparam int TYPE_BITS  = 4;
    localparam int CFG_BITS   = 4;
    localparam int ID_CAP     = (MAX_CELLS < 255) ? MAX_CELLS : 255;
    localparam int ADDR_BITS  = ($clog2(MAX_CELLS) > 0) ? $clog2(MAX_CELLS) : 1;
    localparam int CNT_BITS   = $clog2(NEIGHBORS + 1);
    localparam int WIDE_BITS  = 33;

    localparam logic [ID_BITS-1:0]   ID_CAP_V    = ID_BITS'(ID_CAP);
    localparam logic [CFG_BITS-1:0]  NBR_MAX     = CFG_BITS'(NEIGHBORS);
    localparam logic [CFG_BITS-1:0]  NBR_RESET   = CFG_BITS'(8);
    localparam logic [WIDE_BITS-1:0] AREA_MAX_W  = (WIDE_BITS'(1) << AREA_BITS) - WIDE_BITS'(1);

    // operation codes
    localparam logic [2:0] FN_COPY     = 3'd0;
    localparam logic [2:0] FN_ADD      = 3'd1;
    localparam logic [2:0] FN_REMOVE   = 3'd2;
    localparam logic [2:0] FN_SET_TYPE = 3'd3;
    localparam logic [2:0] FN_KILL     = 3'd4;
    localparam logic [2:0] FN_QUERY    = 3'd5;
    localparam logic [2:0] FN_COUNT    = 3'd6;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_UNUSED = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_SAT    = 2'd3;

    typedef logic [AREA_BITS-1:0] t_area;
    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [CNT_BITS-1:0]  t_cnt;

    typedef struct packed {
        t_area                 area;
        logic [PERIM_BITS-1:0] perim;
        logic [TYPE_BITS-1:0]  ctype;
    } t_entry;

    typedef struct packed {
        logic [2:0]            func;
        logic [ID_BITS-1:0]    source_id;
        logic [ID_BITS-1:0]    target_id;
        logic [63:0]           neighbor_ids;
        logic [15:0]           area_value;
        logic [15:0]           perimeter_value;
        logic [TYPE_BITS-1:0]  type_value;
    } t_in;

    typedef struct packed {
        logic [ID_BITS-1:0]    new_id;
        logic [15:0]           area;
        logic [15:0]           perimeter;
        logic [TYPE_BITS-1:0]  cell_type;
        logic [7:0]            live_count;
        logic [1:0]            status;
    } t_out;

    typedef struct packed {
        logic src;
        logic tgt;
    } t_hit;

    // table writes and result worked out for one item
    typedef struct packed {
        logic   wr1_en;
        t_addr  wr1_addr;
        t_entry wr1_data;
        logic   wr2_en;
        t_addr  wr2_addr;
        t_entry wr2_data;
        logic   add_cell;
        t_out   res;
    } t_upd;

    // table row of a cell id (ids start at 1)
    function automatic t_addr f_id_addr(input logic [ID_BITS-1:0] id);
        logic [ID_BITS-1:0] d;
        d = id - ID_BITS'(1);
        return t_addr'(d);
    endfunction

endpackage

// ===== design/capt_ram.sv =====
// capt_ram: generic RAM, one write port and two registered read ports
// stand-alone, no package needed

module capt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // write and registered reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== design/capt_lane.sv =====
// capt_lane: one neighbor lane, compares a neighbor id with the source and target ids
// uses capt_pkg

module capt_lane (
    input  logic [capt_pkg::ID_BITS-1:0] i_nbr_id,
    input  logic [capt_pkg::ID_BITS-1:0] i_src_id,
    input  logic [capt_pkg::ID_BITS-1:0] i_tgt_id,
    input  logic                         i_en,
    output capt_pkg::t_hit               o_hit
);
    import capt_pkg::*;

    // a lane past the neighbor count never hits
    always_comb begin
        o_hit.src = i_en && (i_nbr_id == i_src_id);
        o_hit.tgt = i_en && (i_nbr_id == i_tgt_id);
    end

endmodule

// ===== design/capt_merge.sv =====
// capt_merge: adds up the lane hits into registered neighbor match counts
// uses capt_pkg

module capt_merge (
    input  logic           i_clk,
    input  logic           i_load,
    input  capt_pkg::t_hit i_hits [capt_pkg::NEIGHBORS],
    output capt_pkg::t_cnt o_eq_s,
    output capt_pkg::t_cnt o_eq_t
);
    import capt_pkg::*;

    t_cnt sum_s;
    t_cnt sum_t;
    t_cnt r_eq_s;
    t_cnt r_eq_t;

    // count of matching lanes
    always_comb begin
        sum_s = '0;
        sum_t = '0;
        for (int i = 0; i < NEIGHBORS; i++) begin
            sum_s = sum_s + t_cnt'(i_hits[i].src);
            sum_t = sum_t + t_cnt'(i_hits[i].tgt);
        end
    end

    // captured with the item
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_eq_s <= sum_s;
            r_eq_t <= sum_t;
        end
    end

    assign o_eq_s = r_eq_s;
    assign o_eq_t = r_eq_t;

endmodule

// ===== design/capt_update.sv =====
// capt_update: entry arithmetic for every operation, table writes and the result item
// uses capt_pkg

module capt_update (
    input  capt_pkg::t_in                 i_item,
    input  logic [capt_pkg::CFG_BITS-1:0] i_nbr_n,
    input  capt_pkg::t_cnt                i_eq_s,
    input  capt_pkg::t_cnt                i_eq_t,
    input  capt_pkg::t_entry              i_ent_a,
    input  capt_pkg::t_entry              i_ent_b,
    input  logic [capt_pkg::ID_BITS-1:0]  i_cells,
    input  logic [7:0]                    i_live,
    output capt_pkg::t_upd                o_upd
);
    import capt_pkg::*;

    logic [ID_BITS-1:0]   src;
    logic [ID_BITS-1:0]   tgt;
    logic                 src_live;
    logic                 tgt_live;
    logic                 same;
    t_entry               s_new;
    t_entry               t_base;
    t_entry               t_new;
    t_entry               ent;
    t_entry               shown;
    logic                 s_sat;
    logic                 t_sat;
    logic [17:0]          s_pv;
    logic [17:0]          t_pv;
    logic [WIDE_BITS-1:0] aval_w;
    logic [WIDE_BITS-1:0] area_w;
    logic [WIDE_BITS-1:0] diff_w;
    logic [WIDE_BITS-1:0] show_w;
    logic                 show_en;

    assign src      = i_item.source_id;
    assign tgt      = i_item.target_id;
    assign src_live = (src != '0) && (src <= i_cells);
    assign tgt_live = (tgt != '0) && (tgt <= i_cells);
    assign same     = (src == tgt);
    assign aval_w   = WIDE_BITS'(i_item.area_value);
    assign area_w   = WIDE_BITS'(i_ent_a.area);
    assign diff_w   = area_w - aval_w;

    // copy, source side: grow by one site, perimeter by n - 2*eq
    always_comb begin
        s_new = i_ent_a;
        s_sat = 1'b0;
        s_pv  = 18'(i_ent_a.perim) + 18'(i_nbr_n) - (18'(i_eq_s) << 1);
        if (&i_ent_a.area) begin
            s_sat = 1'b1;
        end else begin
            s_new.area = i_ent_a.area + AREA_BITS'(1);
        end
        if (s_pv[17]) begin
            s_new.perim = '0;
            s_sat       = 1'b1;
        end else if (s_pv[16]) begin
            s_new.perim = '1;
            s_sat       = 1'b1;
        end else begin
            s_new.perim = s_pv[15:0];
        end
    end

    // copy, target side: shrink by one site, perimeter by 2*eq - n
    always_comb begin
        t_base = (same && src != '0) ? s_new : i_ent_b;
        t_new  = t_base;
        t_sat  = 1'b0;
        t_pv   = 18'(t_base.perim) + (18'(i_eq_t) << 1) - 18'(i_nbr_n);
        if (t_base.area == '0) begin
            t_sat = 1'b1;
        end else begin
            t_new.area = t_base.area - AREA_BITS'(1);
        end
        if (t_pv[17]) begin
            t_new.perim = '0;
            t_sat       = 1'b1;
        end else if (t_pv[16]) begin
            t_new.perim = '1;
            t_sat       = 1'b1;
        end else begin
            t_new.perim = t_pv[15:0];
        end
    end

    // per-operation writes and result
    always_comb begin
        o_upd   = '0;
        ent     = i_ent_a;
        shown   = i_ent_a;
        show_en = 1'b0;
        case (i_item.func)
            FN_COPY: begin
                if ((src != '0 && !src_live) || (tgt != '0 && !tgt_live)) begin
                    o_upd.res.status = ST_UNUSED;
                end else begin
                    if (src != '0 && !same) begin
                        o_upd.wr1_en   = 1'b1;
                        o_upd.wr1_addr = f_id_addr(src);
                        o_upd.wr1_data = s_new;
                        if (tgt != '0) begin
                            o_upd.wr2_en   = 1'b1;
                            o_upd.wr2_addr = f_id_addr(tgt);
                            o_upd.wr2_data = t_new;
                        end
                    end else if (tgt != '0) begin
                        o_upd.wr1_en   = 1'b1;
                        o_upd.wr1_addr = f_id_addr(tgt);
                        o_upd.wr1_data = t_new;
                    end
                    if ((src != '0 && s_sat) || (tgt != '0 && t_sat)) begin
                        o_upd.res.status = ST_SAT;
                    end
                    show_en = (src != '0);
                    shown   = same ? t_new : s_new;
                end
            end
            FN_ADD: begin
                if (i_cells >= ID_CAP_V) begin
                    o_upd.res.status = ST_FULL;
                end else begin
                    if (aval_w > AREA_MAX_W) begin
                        ent.area         = '1;
                        o_upd.res.status = ST_SAT;
                    end else begin
                        ent.area = aval_w[AREA_BITS-1:0];
                    end
                    ent.perim        = i_item.perimeter_value;
                    ent.ctype        = i_item.type_value;
                    o_upd.wr1_en     = 1'b1;
                    o_upd.wr1_addr   = t_addr'(i_cells);
                    o_upd.wr1_data   = ent;
                    o_upd.add_cell   = 1'b1;
                    o_upd.res.new_id = i_cells + ID_BITS'(1);
                    show_en          = 1'b1;
                    shown            = ent;
                end
            end
            FN_REMOVE: begin
                if (!src_live) begin
                    o_upd.res.status = ST_UNUSED;
                end else begin
                    if (area_w < aval_w) begin
                        ent.area         = '0;
                        o_upd.res.status = ST_SAT;
                    end else begin
                        ent.area = diff_w[AREA_BITS-1:0];
                    end
                    o_upd.wr1_en   = 1'b1;
                    o_upd.wr1_addr = f_id_addr(src);
                    o_upd.wr1_data = ent;
                    show_en        = 1'b1;
                    shown          = ent;
                end
            end
            FN_SET_TYPE: begin
                if (!src_live) begin
                    o_upd.res.status = ST_UNUSED;
                end else begin
                    ent.ctype      = i_item.type_value;
                    o_upd.wr1_en   = 1'b1;
                    o_upd.wr1_addr = f_id_addr(src);
                    o_upd.wr1_data = ent;
                    show_en        = 1'b1;
                    shown          = ent;
                end
            end
            FN_KILL: begin
                if (!src_live) begin
                    o_upd.res.status = ST_UNUSED;
                end else begin
                    ent.area       = '0;
                    ent.perim      = '0;
                    o_upd.wr1_en   = 1'b1;
                    o_upd.wr1_addr = f_id_addr(src);
                    o_upd.wr1_data = ent;
                    show_en        = 1'b1;
                    shown          = ent;
                end
            end
            FN_QUERY: begin
                if (!src_live) begin
                    o_upd.res.status = ST_UNUSED;
                end else begin
                    show_en = 1'b1;
                end
            end
            FN_COUNT: begin
                o_upd.res.live_count = i_live;
            end
            default: begin
                o_upd.res.status = ST_UNUSED;
            end
        endcase
        show_w = WIDE_BITS'(shown.area);
        if (show_en) begin
            o_upd.res.area      = show_w[15:0];
            o_upd.res.perimeter = shown.perim;
            o_upd.res.cell_type = shown.ctype;
        end
    end

endmodule

// ===== design/cell_area_perimeter_table.sv =====
// cell_area_perimeter_table: an item is worked in S_EXEC, its result registered or held in
// S_HOLD while the output stalls; a copy between two different cells writes its target in
// S_WR2 (one table write port). Items are taken only in S_IDLE; count type walks the table one
// row a cycle through read port a in S_CNT.
// reset: cell count zero, neighbor count 8, output empty; table rows are not cleared,
// a row is only read once an add cell has written it.

module cell_area_perimeter_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [capt_pkg::CFG_BITS-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  capt_pkg::t_in                 i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output capt_pkg::t_out                o_out_item
);
    import capt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WR2,
        S_CNT,
        S_HOLD
    } t_state;

    t_state               r_state, n_state;
    t_in                  r_item, n_item;
    logic [ID_BITS-1:0]   r_cells, n_cells;
    logic [CFG_BITS-1:0]  r_cfg, n_cfg;
    logic [ID_BITS-1:0]   r_idx, n_idx;
    logic [7:0]           r_live, n_live;
    t_addr                r_wr2_addr, n_wr2_addr;
    t_entry               r_wr2_data, n_wr2_data;
    t_out                 r_res, n_res;
    t_out                 r_out, n_out;
    logic                 r_out_valid, n_out_valid;

    logic [CFG_BITS-1:0]  nbr_n;
    t_hit                 hits [NEIGHBORS];
    t_cnt                 eq_s;
    t_cnt                 eq_t;
    logic [$bits(t_entry)-1:0] rd_a;
    logic [$bits(t_entry)-1:0] rd_b;
    t_entry               ent_a;
    t_entry               ent_b;
    t_upd                 upd;
    logic                 ram_we;
    t_addr                ram_waddr;
    t_entry               ram_wdata;
    t_addr                ram_raddr_a;
    t_addr                ram_raddr_b;
    logic                 accept;
    logic                 out_free;
    logic                 cnt_hit;
    logic [7:0]           live_nx;

    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign nbr_n    = (r_cfg > NBR_MAX) ? NBR_MAX : r_cfg;

    // neighbor lanes, one per packed neighbor id
    for (genvar g = 0; g < NEIGHBORS; g++) begin : g_lane
        capt_lane u_lane (
            .i_nbr_id (i_in_item.neighbor_ids[8*g +: 8]),
            .i_src_id (i_in_item.source_id),
            .i_tgt_id (i_in_item.target_id),
            .i_en     (nbr_n > CFG_BITS'(g)),
            .o_hit    (hits[g])
        );
    end

    // merge lane hits into match counts
    capt_merge u_merge (
        .i_clk  (i_clk),
        .i_load (accept),
        .i_hits (hits),
        .o_eq_s (eq_s),
        .o_eq_t (eq_t)
    );

    // table port selection
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = upd.wr1_addr;
        ram_wdata = upd.wr1_data;
        if (r_state == S_EXEC) begin
            ram_we = upd.wr1_en;
        end else if (r_state == S_WR2) begin
            ram_we    = 1'b1;
            ram_waddr = r_wr2_addr;
            ram_wdata = r_wr2_data;
        end
        if (r_state == S_CNT) begin
            ram_raddr_a = t_addr'(r_idx);
        end else if (i_in_item.func == FN_COUNT) begin
            ram_raddr_a = '0;
        end else begin
            ram_raddr_a = f_id_addr(i_in_item.source_id);
        end
        ram_raddr_b = f_id_addr(i_in_item.target_id);
    end

    // area, perimeter and type table
    capt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_CELLS)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .o_rdata_a (rd_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_b (rd_b)
    );

    assign ent_a = rd_a;
    assign ent_b = rd_b;

    // operation arithmetic
    capt_update u_update (
        .i_item  (r_item),
        .i_nbr_n (nbr_n),
        .i_eq_s  (eq_s),
        .i_eq_t  (eq_t),
        .i_ent_a (ent_a),
        .i_ent_b (ent_b),
        .i_cells (r_cells),
        .i_live  (r_live),
        .o_upd   (upd)
    );

    // type count over the table
    assign cnt_hit = (ent_a.ctype == r_item.type_value) && (ent_a.area != '0);
    assign live_nx = r_live + 8'(cnt_hit);

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_cells     = r_cells;
        n_cfg       = r_cfg;
        n_idx       = r_idx;
        n_live      = r_live;
        n_wr2_addr  = r_wr2_addr;
        n_wr2_data  = r_wr2_data;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        if (i_cfg_valid) begin
            n_cfg = i_cfg_data;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in_item;
                    n_live = '0;
                    if (i_in_item.func == FN_COUNT && r_cells != '0) begin
                        n_idx   = ID_BITS'(1);
                        n_state = S_CNT;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                n_res = upd.res;
                if (upd.add_cell) begin
                    n_cells = r_cells + ID_BITS'(1);
                end
                if (upd.wr2_en) begin
                    n_wr2_addr = upd.wr2_addr;
                    n_wr2_data = upd.wr2_data;
                    n_state    = S_WR2;
                end else if (out_free) begin
                    n_out       = upd.res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_HOLD;
                end
            end
            S_WR2, S_HOLD: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_HOLD;
                end
            end
            S_CNT: begin
                if (r_idx < r_cells) begin
                    n_idx  = r_idx + ID_BITS'(1);
                    n_live = live_nx;
                end else begin
                    n_res            = '0;
                    n_res.live_count = live_nx;
                    n_res.status     = ST_OK;
                    n_state          = S_HOLD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_idx      <= n_idx;
        r_live     <= n_live;
        r_wr2_addr <= n_wr2_addr;
        r_wr2_data <= n_wr2_data;
        r_res      <= n_res;
        r_out      <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cells     <= '0;
            r_cfg       <= NBR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cells     <= n_cells;
            r_cfg       <= n_cfg;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // cell count never passes the id limit
    a_cells_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cells <= ID_CAP_V)
        else $error("cell count above id limit");

    // an accepted item always leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state != S_IDLE)
        else $error("item accepted but sequencer stayed idle");

    // table walk stays within the cells in use
    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CNT |-> (r_idx != '0 && r_idx <= r_cells))
        else $error("type count walk out of range");

    // a full table report only when the table really is full
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == ST_FULL) |-> r_cells == ID_CAP_V)
        else $error("table full reported below the id limit");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for cell_area_perimeter_table, predicting each result
// from its own copy of the cell table; depends on capt_pkg and the design top level

module testbench;
    import capt_pkg::*;

    localparam logic [2:0] FN_UNKNOWN = 3'd7;
    localparam int IDLE_LIMIT = 3000;
    localparam int TAIL_CYCLES = 8;
    localparam int PERIM_TOP = (1 << PERIM_BITS) - 1;
    localparam t_area AREA_TOP = '1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic [CFG_BITS-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    t_in in_item = '0;
    logic out_ready = 1'b0;
    logic cfg_ready;
    logic in_ready;
    logic out_valid;
    t_out out_item;

    // predicted copy of the cell table and the register
    t_area cell_area [1:MAX_CELLS];
    logic [PERIM_BITS-1:0] cell_perim [1:MAX_CELLS];
    logic [TYPE_BITS-1:0] cell_kind [1:MAX_CELLS];
    int live_cells = 0;
    logic [CFG_BITS-1:0] nbr_setting = NBR_RESET;

    // results predicted for accepted items, oldest first
    t_out predicted_out [$];

    // run control and bookkeeping
    bit no_idle = 1'b0;
    int rx_hold_len = 0;
    int mismatches = 0;
    int items_sent = 0;
    int results_checked = 0;
    int cfg_writes = 0;
    int ops_sent [8] = '{default: 0};

    cell_area_perimeter_table DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    // 20 ns clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit id_in_use(input logic [ID_BITS-1:0] id);
        return id != 0 && int'(id) <= live_cells;
    endfunction

    // saturate a perimeter sum, flag in the top bit
    function automatic logic [PERIM_BITS:0] clamp_perim(input int v);
        if (v < 0) return {1'b1, {PERIM_BITS{1'b0}}};
        if (v > PERIM_TOP) return {1'b1, {PERIM_BITS{1'b1}}};
        return {1'b0, PERIM_BITS'(v)};
    endfunction

    // apply one item to the table copy and work out its result
    function automatic t_out predict_table_op(input t_in it);
        t_out res;
        logic [ID_BITS-1:0] shown;
        logic [ID_BITS-1:0] nbr;
        int n;
        int eq_s;
        int eq_t;
        int cnt;
        logic sat;
        res = '0;
        shown = '0;
        res.status = ST_OK;
        case (it.func)
            FN_COPY: begin
                if ((it.source_id != 0 && !id_in_use(it.source_id)) ||
                    (it.target_id != 0 && !id_in_use(it.target_id))) begin
                    res.status = ST_UNUSED;
                end else begin
                    n = (int'(nbr_setting) > NEIGHBORS) ? NEIGHBORS : int'(nbr_setting);
                    eq_s = 0;
                    eq_t = 0;
                    for (int i = 0; i < n; i++) begin
                        nbr = it.neighbor_ids[8*i +: 8];
                        if (nbr == it.source_id) eq_s++;
                        if (nbr == it.target_id) eq_t++;
                    end
                    // source grows first, then target shrinks
                    if (it.source_id != 0) begin
                        if (cell_area[it.source_id] == AREA_TOP) res.status = ST_SAT;
                        else cell_area[it.source_id] = cell_area[it.source_id] + 1'b1;
                        {sat, cell_perim[it.source_id]} =
                            clamp_perim(int'(cell_perim[it.source_id]) + n - 2 * eq_s);
                        if (sat) res.status = ST_SAT;
                    end
                    if (it.target_id != 0) begin
                        if (cell_area[it.target_id] == 0) res.status = ST_SAT;
                        else cell_area[it.target_id] = cell_area[it.target_id] - 1'b1;
                        {sat, cell_perim[it.target_id]} =
                            clamp_perim(int'(cell_perim[it.target_id]) + 2 * eq_t - n);
                        if (sat) res.status = ST_SAT;
                    end
                    shown = it.source_id;
                end
            end
            FN_ADD: begin
                if (live_cells >= ID_CAP) begin
                    res.status = ST_FULL;
                end else begin
                    live_cells++;
                    if (int'(it.area_value) > int'(AREA_TOP)) begin
                        cell_area[live_cells] = AREA_TOP;
                        res.status = ST_SAT;
                    end else begin
                        cell_area[live_cells] = t_area'(it.area_value);
                    end
                    cell_perim[live_cells] = it.perimeter_value;
                    cell_kind[live_cells] = it.type_value;
                    res.new_id = ID_BITS'(live_cells);
                    shown = ID_BITS'(live_cells);
                end
            end
            FN_REMOVE: begin
                if (!id_in_use(it.source_id)) begin
                    res.status = ST_UNUSED;
                end else begin
                    if (cell_area[it.source_id] < it.area_value) begin
                        cell_area[it.source_id] = '0;
                        res.status = ST_SAT;
                    end else begin
                        cell_area[it.source_id] = cell_area[it.source_id] - it.area_value;
                    end
                    shown = it.source_id;
                end
            end
            FN_SET_TYPE: begin
                if (!id_in_use(it.source_id)) res.status = ST_UNUSED;
                else begin
                    cell_kind[it.source_id] = it.type_value;
                    shown = it.source_id;
                end
            end
            FN_KILL: begin
                if (!id_in_use(it.source_id)) res.status = ST_UNUSED;
                else begin
                    cell_area[it.source_id] = '0;
                    cell_perim[it.source_id] = '0;
                    shown = it.source_id;
                end
            end
            FN_QUERY: begin
                if (!id_in_use(it.source_id)) res.status = ST_UNUSED;
                else shown = it.source_id;
            end
            FN_COUNT: begin
                cnt = 0;
                for (int i = 1; i <= live_cells; i++)
                    if (cell_kind[i] == it.type_value && cell_area[i] != 0) cnt++;
                res.live_count = 8'(cnt);
            end
            default: res.status = ST_UNUSED;
        endcase
        if (shown != 0) begin
            res.area = 16'(cell_area[shown]);
            res.perimeter = cell_perim[shown];
            res.cell_type = cell_kind[shown];
        end
        return res;
    endfunction

    function automatic t_in make_item(input logic [2:0] f, input logic [7:0] src,
                                      input logic [7:0] tgt, input logic [63:0] nb,
                                      input logic [15:0] av, input logic [15:0] pv,
                                      input logic [3:0] tv);
        t_in it;
        it.func = f;
        it.source_id = src;
        it.target_id = tgt;
        it.neighbor_ids = nb;
        it.area_value = av;
        it.perimeter_value = pv;
        it.type_value = tv;
        return it;
    endfunction

    // mostly live ids, some medium and some anywhere in the id range
    function automatic logic [7:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 8'd0;
        if (r < 16 || live_cells == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(1, live_cells));
    endfunction

    // neighbor bytes built around the two ids so the perimeter deltas vary
    function automatic logic [63:0] pick_neighbors(input logic [7:0] src,
                                                   input logic [7:0] tgt);
        logic [63:0] nb;
        if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
        for (int i = 0; i < 8; i++) begin
            case ($urandom_range(0, 4))
                0: nb[8*i +: 8] = src;
                1: nb[8*i +: 8] = tgt;
                2: nb[8*i +: 8] = 8'd0;
                3: nb[8*i +: 8] = pick_id();
                default: nb[8*i +: 8] = 8'($urandom);
            endcase
        end
        return nb;
    endfunction

    function automatic t_in random_add();
        t_in it;
        it = make_item(FN_ADD, 8'($urandom), 8'($urandom), {$urandom, $urandom},
                       16'($urandom_range(1, 40)), 16'($urandom_range(0, 30)),
                       4'($urandom));
        if ($urandom_range(0, 7) == 0) it.area_value = 16'($urandom);
        case ($urandom_range(0, 15))
            0: it.perimeter_value = 16'hFFFF;
            1: it.perimeter_value = 16'h0000;
            2: it.perimeter_value = 16'($urandom);
            default: ;
        endcase
        return it;
    endfunction

    function automatic t_in random_item();
        t_in it;
        int r;
        it = make_item(3'($urandom), 8'($urandom), 8'($urandom), {$urandom, $urandom},
                       16'($urandom), 16'($urandom), 4'($urandom));
        r = $urandom_range(0, 99);
        if (r < 2) begin
            // raw noise, any func
        end else if (r < 46) begin
            it.func = FN_COPY;
            it.source_id = pick_id();
            it.target_id = pick_id();
            it.neighbor_ids = pick_neighbors(it.source_id, it.target_id);
        end else if (r < 56) begin
            it = random_add();
        end else if (r < 64) begin
            it.func = FN_REMOVE;
            it.source_id = pick_id();
            if ($urandom_range(0, 4) != 0) it.area_value = 16'($urandom_range(0, 8));
        end else if (r < 72) begin
            it.func = FN_SET_TYPE;
            it.source_id = pick_id();
        end else if (r < 77) begin
            it.func = FN_KILL;
            it.source_id = pick_id();
        end else if (r < 90) begin
            it.func = FN_QUERY;
            it.source_id = pick_id();
        end else if (r < 96) begin
            it.func = FN_COUNT;
            if (live_cells > 0 && $urandom_range(0, 1) == 1)
                it.type_value = cell_kind[$urandom_range(1, live_cells)];
        end else begin
            it.func = FN_UNKNOWN;
        end
        return it;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatches++;
        $display("mismatch at %0t: %s got %0h, predicted %0h", $time, what, got, want);
    endtask

    // offer one item after a random gap, predict it once accepted
    task automatic send_item(input t_in item);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item <= item;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        predicted_out = {predicted_out, predict_table_op(item)};
        items_sent++;
        ops_sent[item.func]++;
    endtask

    // sender goes quiet until every predicted result is back
    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (predicted_out.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_neighbor_setting(input logic [CFG_BITS-1:0] value);
        @(negedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        nbr_setting = value;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // result side: random stalls, or one long hold when asked
    initial begin : result_sink
        int stall;
        forever begin
            if (rx_hold_len > 0) begin
                stall = rx_hold_len;
                rx_hold_len = 0;
            end else if (no_idle) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 7);
            end
            repeat (stall) begin
                @(negedge clk);
                out_ready <= 1'b0;
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // compare each accepted result with the oldest prediction
    always @(posedge clk) begin : check_result
        t_out want;
        if (rst_n && out_valid && out_ready) begin
            if (predicted_out.size() == 0) begin
                report_mismatch("result with nothing pending", out_item, 0);
            end else begin
                want = predicted_out.pop_front();
                results_checked++;
                if (out_item.new_id !== want.new_id)
                    report_mismatch("new_id", out_item.new_id, want.new_id);
                if (out_item.area !== want.area)
                    report_mismatch("area", out_item.area, want.area);
                if (out_item.perimeter !== want.perimeter)
                    report_mismatch("perimeter", out_item.perimeter, want.perimeter);
                if (out_item.cell_type !== want.cell_type)
                    report_mismatch("cell_type", out_item.cell_type, want.cell_type);
                if (out_item.live_count !== want.live_count)
                    report_mismatch("live_count", out_item.live_count, want.live_count);
                if (out_item.status !== want.status)
                    report_mismatch("status", out_item.status, want.status);
            end
        end
    end

    // end the run if nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("cell_area_perimeter_table test failed");
        $finish;
    end

    // empty table, extreme fields, saturation and unused ids
    task automatic test_directed();
        send_item(make_item(FN_QUERY, 8'd0, 8'd0, 64'd0, 16'd0, 16'd0, 4'd0));
        send_item(make_item(FN_QUERY, 8'd1, 8'd0, 64'd0, 16'd0, 16'd0, 4'd0));
        send_item(make_item(FN_COPY, 8'd1, 8'd0, 64'd0, 16'd0, 16'd0, 4'd0));
        send_item(make_item(FN_COUNT, 8'd0, 8'd0, 64'd0, 16'd0, 16'd0, 4'd0));
        send_item(make_item(FN_ADD, 8'd0, 8'd0, 64'd0, 16'd0, 16'd0, 4'd0));
        send_item(make_item(FN_ADD, 8'hFF, 8'hFF, '1, 16'hFFFF, 16'hFFFF, 4'hF));
        send_item(make_item(FN_ADD, 8'd0, 8'd0, 64'd0, 16'd10, 16'd4, 4'd5));
        // both areas and perimeters pinned at their limits
        send_item(make_item(FN_COPY, 8'd2, 8'd1, 64'd0, 16'd0, 16'd0, 4'd0));
        // copy onto the same cell, all neighbors equal
        send_item(make_item(FN_COPY, 8'd3, 8'd3, {8{8'd3}}, 16'd0, 16'd0, 4'd0));
        // medium on either side
        send_item(make_item(FN_COPY, 8'd0, 8'd3, 64'h0003_0000_0300_0001, 16'd0, 16'd0,
                            4'd0));
        send_item(make_item(FN_COPY, 8'd3, 8'd0, 64'h0000_0003_0003_0000, 16'd0, 16'd0,
                            4'd0));
        send_item(make_item(FN_COPY, 8'd0, 8'd0, 64'd0, 16'd0, 16'd0, 4'd0));
        send_item(make_item(FN_COPY, 8'd3, 8'd200, 64'd0, 16'd0, 16'd0, 4'd0));
        send_item(make_item(FN_REMOVE, 8'd3, 8'd0, 64'd0, 16'd5, 16'd0, 4'd0));
        send_item(make_item(FN_REMOVE, 8'd3, 8'd0, 64'd0, 16'hFFFF, 16'd0, 4'd0));
        send_item(make_item(FN_SET_TYPE, 8'd3, 8'd0, 64'd0, 16'd0, 16'd0, 4'hF));
        send_item(make_item(FN_SET_TYPE, 8'd9, 8'd0, 64'd0, 16'd0, 16'd0, 4'd2));
        send_item(make_item(FN_KILL, 8'd2, 8'd0, 64'd0, 16'd0, 16'd0, 4'd0));
        send_item(make_item(FN_KILL, 8'd0, 8'd0, 64'd0, 16'd0, 16'd0, 4'd0));
        send_item(make_item(FN_QUERY, 8'd2, 8'd0, 64'd0, 16'd0, 16'd0, 4'd0));
        send_item(make_item(FN_COUNT, 8'd0, 8'd0, 64'd0, 16'd0, 16'd0, 4'hF));
        send_item(make_item(FN_UNKNOWN, 8'd1, 8'd2, '1, 16'hFFFF, 16'hFFFF, 4'hF));
        send_item(make_item(FN_COPY, 8'd1, 8'd2, '1, 16'd0, 16'd0, 4'd0));
        send_item(make_item(FN_REMOVE, 8'hFF, 8'd0, 64'd0, 16'd1, 16'd0, 4'd0));
        send_item(make_item(FN_ADD, 8'd0, 8'd0, 64'd0, 16'd1, 16'd1, 4'd0));
        send_item(make_item(FN_COUNT, 8'd0, 8'd0, 64'd0, 16'd0, 16'd0, 4'd0));
    endtask

    // random traffic under six neighbor count settings, extremes included
    task automatic test_neighbor_settings();
        logic [CFG_BITS-1:0] value;
        for (int k = 0; k < 6; k++) begin
            case (k)
                0: value = 4'd0;
                1: value = 4'd1;
                2: value = 4'd4;
                3: value = 4'd15;
                4: value = 4'($urandom_range(9, 14));
                default: value = 4'($urandom_range(2, 7));
            endcase
            wait_for_results();
            write_neighbor_setting(value);
            repeat (16) send_item(random_item());
        end
    endtask

    // long result stall while items keep coming, then a full pause
    task automatic test_backpressure();
        rx_hold_len = 80;
        no_idle = 1'b1;
        repeat (24) send_item(random_item());
        no_idle = 1'b0;
        wait_for_results();
    endtask

    // grow the table to its limit, then try to add more
    task automatic test_table_full();
        while (live_cells < ID_CAP) begin
            send_item(random_add());
            if ($urandom_range(0, 4) == 0) send_item(random_item());
        end
        repeat (3) send_item(random_add());
        send_item(make_item(FN_COUNT, 8'd0, 8'd0, 64'd0, 16'd0, 16'd0, 4'($urandom)));
    endtask

    // random traffic over the full id range
    task automatic test_full_table_mix();
        wait_for_results();
        write_neighbor_setting(NBR_RESET);
        repeat (30) send_item(random_item());
        wait_for_results();
        write_neighbor_setting(4'd4);
        no_idle = 1'b1;
        repeat (15) send_item(random_item());
        no_idle = 1'b0;
        repeat (15) send_item(random_item());
    endtask

    initial begin : run
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_neighbor_settings();
        test_backpressure();
        test_table_full();
        test_full_table_mix();
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("covered %0d items: %0d copies, %0d adds, %0d count walks, %0d others",
                 items_sent, ops_sent[FN_COPY], ops_sent[FN_ADD], ops_sent[FN_COUNT],
                 items_sent - ops_sent[FN_COPY] - ops_sent[FN_ADD] - ops_sent[FN_COUNT]);
        $display("%0d neighbor count writes, table grown to %0d cells, %0d results checked",
                 cfg_writes, live_cells, results_checked);
        if (mismatches == 0)
            $display("cell_area_perimeter_table test passed");
        else
            $display("cell_area_perimeter_table test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/capt_pkg.sv
design/capt_ram.sv
design/capt_lane.sv
design/capt_merge.sv
design/capt_update.sv
design/cell_area_perimeter_table.sv
test/testbench.sv
